// ===== design/osm_pkg.sv =====
// Shared types and constants for the OFDM subcarrier mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package osm_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_FFT_SIZE    = 3'd0;
    localparam logic [2:0] CFG_GUARD_SIZE  = 3'd1;
    localparam logic [2:0] CFG_PILOT_COUNT = 3'd2;
    localparam logic [2:0] CFG_PILOT_REAL  = 3'd3;
    localparam logic [2:0] CFG_PILOT_IMAG  = 3'd4;

    // Reset values of the registers
    localparam logic [12:0] FFT_SIZE_RST    = 13'd64;
    localparam logic [4:0]  GUARD_SIZE_RST  = 5'd6;
    localparam logic [11:0] PILOT_COUNT_RST = 12'd4;
    localparam logic [15:0] PILOT_REAL_RST  = 16'h7FFF;
    localparam logic [15:0] PILOT_IMAG_RST  = 16'h0000;

    localparam int FFT_MIN     = 8;
    localparam int GUARD_LIMIT = 30;

    // Cycles that the derived values need after a register write
    localparam logic [1:0] CFG_SETTLE = 2'd3;

    typedef enum logic [1:0] {
        KIND_GUARD = 2'd0,
        KIND_PILOT = 2'd1,
        KIND_DATA  = 2'd2
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t kind;
        logic       symbol_end;
    } cell_res_t;

    typedef struct packed {
        logic restart;   // valid register written: restart the symbol
        logic busy;      // derived values still settling
    } cfg_ctrl_t;

endpackage

// ===== design/ofdm_subcarrier_mapper.sv =====
// Top level of the OFDM subcarrier mapper: stream ports, sequencer, output register.
// Depends on osm_pkg, osm_config and osm_cell_unit.
`timescale 1ns / 1ps

// Usage
// - s_ channel: one complex data symbol per request. The block walks the
//   subcarriers of the OFDM symbol and, for each request, emits every guard,
//   DC and pilot cell ahead of the next data subcarrier, then the data cell.
// - m_ channel: one cell per request; tuser gives kind and end of symbol,
//   tlast marks the data cell, the last result of the input request.
// - cfg port: plain writes, only while idle; a write to a known register
//   restarts the symbol at subcarrier 0.
// Timing
// - An input producing n cells occupies the block while it takes the
//   request and then each of its cells in turn; the shared classifier handles
//   one subcarrier per cycle while the output register is free. n is at most 62.
// - s_tready is low while cells are being produced and after reset or a
//   register write, while the derived layout settles.
// - A stalled receiver holds the output register; the sequencer waits and
//   no cell is lost. A new input is taken while the final cell still waits.
// - Reset restores the default registers and restarts at subcarrier 0.

module ofdm_subcarrier_mapper
    import osm_pkg::*;
#(
    parameter int FFT_MAX = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample_real, [31:16] sample_imag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] cell_real, [31:16] cell_imag
    output logic [2:0]  m_tuser,   // [1:0] cell_kind, [2] symbol_end
    output logic        m_tlast,   // run_last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int POS_W = $clog2(FFT_MAX);
    localparam int ACC_W = 2 * POS_W - 1;
    localparam int MW    = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
    localparam logic [15:0] VAL_MASK = 16'((32'd1 << MW) - 32'd1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg;
    logic [POS_W-1:0] pos_reg;
    logic [ACC_W-1:0] target_reg, scaled_reg;
    logic [15:0]      samp_re_reg, samp_im_reg;
    logic             m_valid_reg;
    logic [31:0]      m_data_reg;
    logic [2:0]       m_user_reg;
    logic             m_last_reg;

    cfg_ctrl_t        cfg_ctrl;
    logic [POS_W-1:0] fft_last, start_pos, last_pos, usable;
    logic [POS_W-2:0] pilot_num;
    logic [ACC_W-1:0] pilot_total;
    logic [15:0]      pilot_real, pilot_imag;

    cell_res_t        res;
    logic [POS_W-1:0] pos_next;
    logic [ACC_W-1:0] target_next, scaled_next;

    logic             s_fire, out_free, step;
    logic [15:0]      cell_re, cell_im;

    osm_config #(
        .POS_W   (POS_W),
        .ACC_W   (ACC_W),
        .FFT_MAX (FFT_MAX)
    ) u_config (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctrl        (cfg_ctrl),
        .fft_last    (fft_last),
        .start_pos   (start_pos),
        .last_pos    (last_pos),
        .usable      (usable),
        .pilot_num   (pilot_num),
        .pilot_total (pilot_total),
        .pilot_real  (pilot_real),
        .pilot_imag  (pilot_imag)
    );

    osm_cell_unit #(
        .POS_W (POS_W),
        .ACC_W (ACC_W)
    ) u_cell (
        .pos         (pos_reg),
        .target_acc  (target_reg),
        .scaled_acc  (scaled_reg),
        .fft_last    (fft_last),
        .start_pos   (start_pos),
        .last_pos    (last_pos),
        .usable      (usable),
        .pilot_num   (pilot_num),
        .pilot_total (pilot_total),
        .res         (res),
        .pos_next    (pos_next),
        .target_next (target_next),
        .scaled_next (scaled_next)
    );

    assign s_tready = (state_reg == ST_IDLE) && !cfg_ctrl.busy;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign step     = (state_reg == ST_RUN) && out_free;

    always_comb begin
        case (res.kind)
            KIND_PILOT: begin
                cell_re = pilot_real & VAL_MASK;
                cell_im = pilot_imag & VAL_MASK;
            end
            KIND_DATA: begin
                cell_re = samp_re_reg & VAL_MASK;
                cell_im = samp_im_reg & VAL_MASK;
            end
            default: begin
                cell_re = '0;
                cell_im = '0;
            end
        endcase
    end

    // Sequencer and symbol position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            target_reg <= '0;
            scaled_reg <= '0;
        end else if (cfg_ctrl.restart) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            target_reg <= '0;
            scaled_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_RUN;
                        if (pos_reg > fft_last) begin
                            pos_reg    <= '0;
                            target_reg <= '0;
                            scaled_reg <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    if (step) begin
                        pos_reg    <= pos_next;
                        target_reg <= target_next;
                        scaled_reg <= scaled_next;
                        if (res.kind == KIND_DATA) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Input sample hold
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            samp_re_reg <= s_tdata[15:0];
            samp_im_reg <= s_tdata[31:16];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= {cell_im, cell_re};
            m_user_reg <= {res.symbol_end, res.kind};
            m_last_reg <= (res.kind == KIND_DATA);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // the run-end flag only ever comes with the data cell
    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1:0] == KIND_DATA)
        else $error("tlast on a non-data cell");

    // an accepted request with no register write beside it starts cell production
    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !cfg_we |=> state_reg == ST_RUN)
        else $error("accepted request did not start a run");

    // no request is taken while the layout settles after a write
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && cfg_index <= CFG_PILOT_IMAG |=> !s_tready)
        else $error("request accepted right after a register write");
`endif

endmodule

// ===== design/osm_config.sv =====
// Configuration registers and derived symbol layout (clamps, pilot total).
// Depends on osm_pkg.
`timescale 1ns / 1ps

module osm_config
    import osm_pkg::*;
#(
    parameter int POS_W = 12,
    parameter int ACC_W = 23,
    parameter int FFT_MAX = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output cfg_ctrl_t           ctrl,
    output logic [POS_W-1:0]    fft_last,
    output logic [POS_W-1:0]    start_pos,
    output logic [POS_W-1:0]    last_pos,
    output logic [POS_W-1:0]    usable,
    output logic [POS_W-2:0]    pilot_num,
    output logic [ACC_W-1:0]    pilot_total,
    output logic [15:0]         pilot_real,
    output logic [15:0]         pilot_imag
);

    localparam int FE_W = POS_W + 1;
    localparam int FW   = (FE_W > 13) ? FE_W : 13;
    localparam int GW   = (FE_W > 5) ? FE_W : 5;
    localparam int CW   = (POS_W > 12) ? POS_W : 12;
    localparam int NP_W = POS_W - 1;

    logic [12:0] fft_size_reg;
    logic [4:0]  guard_size_reg;
    logic [11:0] pilot_count_reg;
    logic [15:0] pilot_real_reg;
    logic [15:0] pilot_imag_reg;
    logic [1:0]  settle_reg;

    logic [POS_W-1:0] fft_last_reg, start_reg, last_reg, usable_reg;
    logic [NP_W-1:0]  np_reg;
    logic [ACC_W-1:0] total_reg;

    logic             valid_wr;
    logic [FW-1:0]    fsz_w, fft_c;
    logic [FE_W-1:0]  fft_e, half_g;
    logic [GW-1:0]    g_w;
    logic [POS_W-1:0] g_p, start_n, last_n, usable_n, half_u;
    logic [CW-1:0]    np_w;

    assign valid_wr = cfg_we && (cfg_index <= CFG_PILOT_IMAG);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fft_size_reg    <= FFT_SIZE_RST;
            guard_size_reg  <= GUARD_SIZE_RST;
            pilot_count_reg <= PILOT_COUNT_RST;
            pilot_real_reg  <= PILOT_REAL_RST;
            pilot_imag_reg  <= PILOT_IMAG_RST;
            settle_reg      <= CFG_SETTLE;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FFT_SIZE:    fft_size_reg    <= cfg_data[12:0];
                    CFG_GUARD_SIZE:  guard_size_reg  <= cfg_data[4:0];
                    CFG_PILOT_COUNT: pilot_count_reg <= cfg_data[11:0];
                    CFG_PILOT_REAL:  pilot_real_reg  <= cfg_data;
                    CFG_PILOT_IMAG:  pilot_imag_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (valid_wr) begin
                settle_reg <= CFG_SETTLE;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // Stage 1: clamps and band edges
    always_comb begin
        fsz_w = FW'(fft_size_reg);
        if (fsz_w < FW'(FFT_MIN)) begin
            fft_c = FW'(FFT_MIN);
        end else if (fsz_w > FW'(FFT_MAX)) begin
            fft_c = FW'(FFT_MAX);
        end else begin
            fft_c = fsz_w;
        end
        fft_e  = FE_W'(fft_c);
        half_g = (fft_e - FE_W'(2)) >> 1;

        g_w = GW'(guard_size_reg);
        if (g_w > GW'(GUARD_LIMIT)) begin
            g_w = GW'(GUARD_LIMIT);
        end
        if (g_w > GW'(half_g)) begin
            g_w = GW'(half_g);
        end
        g_p = POS_W'(g_w);

        start_n  = (g_p == '0) ? POS_W'(1) : g_p;
        last_n   = POS_W'(fft_e - FE_W'(1) - FE_W'(g_p));
        usable_n = last_n - start_n + POS_W'(1);
        half_u   = usable_n >> 1;

        np_w = CW'(pilot_count_reg);
        if (np_w > CW'(half_u)) begin
            np_w = CW'(half_u);
        end
    end

    always_ff @(posedge aclk) begin
        fft_last_reg <= POS_W'(fft_e - FE_W'(1));
        start_reg    <= start_n;
        last_reg     <= last_n;
        usable_reg   <= usable_n;
        np_reg       <= NP_W'(np_w);
        // Stage 2: i*usable bound for the last pilot
        total_reg    <= ACC_W'(usable_reg) * ACC_W'(np_reg);
    end

    assign ctrl.restart = valid_wr;
    assign ctrl.busy    = (settle_reg != 2'd0);
    assign fft_last     = fft_last_reg;
    assign start_pos    = start_reg;
    assign last_pos     = last_reg;
    assign usable       = usable_reg;
    assign pilot_num    = np_reg;
    assign pilot_total  = total_reg;
    assign pilot_real   = pilot_real_reg;
    assign pilot_imag   = pilot_imag_reg;

endmodule

// ===== design/osm_cell_unit.sv =====
// Shared classifier: kind of one subcarrier and the next position/accumulators.
// Depends on osm_pkg.
`timescale 1ns / 1ps

module osm_cell_unit
    import osm_pkg::*;
#(
    parameter int POS_W = 12,
    parameter int ACC_W = 23
) (
    input  logic [POS_W-1:0] pos,
    input  logic [ACC_W-1:0] target_acc,
    input  logic [ACC_W-1:0] scaled_acc,
    input  logic [POS_W-1:0] fft_last,
    input  logic [POS_W-1:0] start_pos,
    input  logic [POS_W-1:0] last_pos,
    input  logic [POS_W-1:0] usable,
    input  logic [POS_W-2:0] pilot_num,
    input  logic [ACC_W-1:0] pilot_total,
    output cell_res_t        res,
    output logic [POS_W-1:0] pos_next,
    output logic [ACC_W-1:0] target_next,
    output logic [ACC_W-1:0] scaled_next
);

    logic           in_usable, is_pilot, wrap;
    logic [ACC_W:0] window_top;

    always_comb begin
        in_usable  = (pos >= start_pos) && (pos <= last_pos);
        window_top = {1'b0, scaled_acc} + (ACC_W + 1)'(pilot_num);
        // pilot where i*usable falls in [(pos-start)*np, (pos-start+1)*np)
        is_pilot   = in_usable && (pilot_num != '0) && (target_acc < pilot_total)
                     && (target_acc >= scaled_acc)
                     && ({1'b0, target_acc} < window_top);
        wrap       = (pos == fft_last);

        if (!in_usable) begin
            res.kind = KIND_GUARD;
        end else if (is_pilot) begin
            res.kind = KIND_PILOT;
        end else begin
            res.kind = KIND_DATA;
        end
        res.symbol_end = wrap;

        if (wrap) begin
            pos_next    = '0;
            target_next = '0;
            scaled_next = '0;
        end else begin
            pos_next    = pos + POS_W'(1);
            target_next = is_pilot ? target_acc + ACC_W'(usable) : target_acc;
            scaled_next = in_usable ? scaled_acc + ACC_W'(pilot_num) : scaled_acc;
        end
    end

endmodule
